### design/line_track_mode_controller_macros.svh
// Assertion macros for the line-track mode controller.
// Taken in by the top level; relies on clk and rst_n in the including scope.
`ifndef LINE_TRACK_MODE_CONTROLLER_MACROS_SVH
`define LINE_TRACK_MODE_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LTMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LTMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ltmc_pkg.sv
// Package for the line-track mode controller: word types, mode codes,
// register indexes and fixed thresholds. No dependencies.
`timescale 1ns / 1ps

package ltmc_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_CROSS  = 3'd1,
    MODE_FOUND  = 3'd2,
    MODE_ENTER  = 3'd3,
    MODE_INSIDE = 3'd4,
    MODE_EXIT   = 3'd5,
    MODE_ZEBRA  = 3'd6
  } mode_t;

  typedef struct packed {
    logic [7:0]         pattern;
    logic signed [15:0] line_offset;
    logic [7:0]         left_loss_frames;
    logic [7:0]         right_loss_frames;
  } in_word_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [15:0] steer_offset;
    logic [6:0]         speed_limit;
  } out_word_t;

  typedef struct packed {
    logic [6:0]  speed_full;
    logic [6:0]  speed_curve;
    logic [6:0]  speed_island;
    logic [6:0]  speed_zebra;
    logic [7:0]  loss_confirm;
    logic [7:0]  zebra_toggles_needed;
    logic [15:0] zebra_max_gap;
    logic [7:0]  island_shield;
  } cfg_t;

  // Classified frame handed from the front end to the back end.
  typedef struct packed {
    logic               left_dark;
    logic               right_dark;
    logic               curve;
    logic               left_confirmed;
    logic               right_confirmed;
    logic               loss_clear;
    logic signed [15:0] line_offset;
  } cls_word_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_FULL    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_CURVE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_ISLAND  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_ZEBRA   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOSS_CONFIRM  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_ZEBRA_TOGGLES = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_ZEBRA_MAX_GAP = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_ISLAND_SHIELD = 3'd7;

  localparam cfg_t CFG_RESET = '{
    speed_full:           7'd100,
    speed_curve:          7'd70,
    speed_island:         7'd50,
    speed_zebra:          7'd0,
    loss_confirm:         8'd5,
    zebra_toggles_needed: 8'd6,
    zebra_max_gap:        16'd50,
    island_shield:        8'd40
  };

  localparam logic [3:0]         SIDE_MASK   = 4'h0;
  localparam logic signed [15:0] CURVE_MAG   = 16'sd500;
  localparam logic [15:0]        GAP_MAX     = 16'hFFFF;
  localparam logic [7:0]         CROSS_HOLD  = 8'd10;
  localparam logic [7:0]         FOUND_HOLD  = 8'd8;
  localparam logic [7:0]         ENTER_HOLD  = 8'd15;
  localparam logic [7:0]         INSIDE_HOLD = 8'd30;
  localparam logic [7:0]         ONE_TOGGLE  = 8'd1;

endpackage

### design/ltmc_front.sv
// Front end of the line-track mode controller: classifies each input word.
// Depends on ltmc_pkg.
`timescale 1ns / 1ps

module ltmc_front import ltmc_pkg::*; (
  input  in_word_t  in_word,
  input  logic [7:0] loss_confirm,
  output cls_word_t cls_word
);

  always_comb begin
    cls_word.left_dark       = (in_word.pattern[3:0] == SIDE_MASK);
    cls_word.right_dark      = (in_word.pattern[7:4] == SIDE_MASK);
    cls_word.curve           = (in_word.line_offset > CURVE_MAG) ||
                               (in_word.line_offset < -CURVE_MAG);
    cls_word.left_confirmed  = (in_word.left_loss_frames >= loss_confirm);
    cls_word.right_confirmed = (in_word.right_loss_frames >= loss_confirm);
    cls_word.loss_clear      = (in_word.left_loss_frames == 8'd0) &&
                               (in_word.right_loss_frames == 8'd0);
    cls_word.line_offset     = in_word.line_offset;
  end

endmodule

### design/ltmc_queue.sv
// Two-entry queue of classified words between front and back ends.
// Depends on ltmc_pkg.
`timescale 1ns / 1ps

module ltmc_queue import ltmc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cls_word_t push_word,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output cls_word_t head_word
);

  cls_word_t  entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head_word = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

### design/ltmc_back.sv
// Back end of the line-track mode controller: mode state machine, tracking
// state and the output register. Depends on ltmc_pkg.
`timescale 1ns / 1ps

module ltmc_back import ltmc_pkg::*; #(
  parameter int unsigned ZEBRA_MIN_HOLD = 20,
  parameter int unsigned ZEBRA_TIMEOUT  = 200
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      head_valid,
  input  cls_word_t head_word,
  output logic      head_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  localparam logic [7:0] MIN_HOLD = 8'(ZEBRA_MIN_HOLD);
  localparam logic [7:0] TIMEOUT  = 8'(ZEBRA_TIMEOUT);

  mode_t              mode_r, mode_nxt;
  logic [7:0]         frame_r, frame_nxt;
  logic signed [15:0] held_r, held_nxt;
  logic               prev_lost_r, prev_lost_nxt;
  logic [7:0]         tog_r, tog_nxt;
  logic [15:0]        gap_r, gap_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r;

  logic               take;
  logic               both, seen;
  logic [7:0]         frame_inc;
  logic [15:0]        gap_inc, gap_upd;
  logic               tog_event;
  logic [7:0]         tog_upd;
  logic               prev_upd;
  logic               go_zebra, go_cross, go_found;
  logic signed [15:0] steer;
  logic [6:0]         speed;

  assign take      = head_valid && (!out_valid_r || out_ready);
  assign head_pop  = take;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    both      = head_word.left_dark && head_word.right_dark;
    seen      = !both;
    frame_inc = frame_r + 8'd1;
    gap_inc   = (gap_r == GAP_MAX) ? gap_r : gap_r + 16'd1;
    tog_event = both ? !prev_lost_r : prev_lost_r;
    if (tog_event) begin
      tog_upd  = (((tog_r != 8'd0) && (gap_inc > cfg.zebra_max_gap)) ? 8'd0 : tog_r) + 8'd1;
      prev_upd = both;
      gap_upd  = 16'd0;
    end else begin
      tog_upd  = tog_r;
      prev_upd = prev_lost_r;
      gap_upd  = gap_inc;
    end
    go_zebra = both && (tog_upd >= cfg.zebra_toggles_needed);
    go_cross = both && head_word.left_confirmed && head_word.right_confirmed &&
               (tog_upd <= ONE_TOGGLE);
    go_found = (head_word.left_dark && !head_word.right_dark && head_word.left_confirmed) ||
               (head_word.right_dark && !head_word.left_dark && head_word.right_confirmed);
  end

  always_comb begin
    mode_nxt = mode_r;
    unique case (mode_r)
      MODE_CROSS: begin
        if (seen && (frame_inc > CROSS_HOLD)) mode_nxt = MODE_NORMAL;
      end
      MODE_FOUND: begin
        if (frame_inc > FOUND_HOLD) mode_nxt = MODE_ENTER;
      end
      MODE_ENTER: begin
        if (frame_inc > ENTER_HOLD) mode_nxt = MODE_INSIDE;
      end
      MODE_INSIDE: begin
        if (seen && (frame_inc > INSIDE_HOLD)) mode_nxt = MODE_EXIT;
      end
      MODE_EXIT: begin
        if (frame_inc > cfg.island_shield) mode_nxt = MODE_NORMAL;
      end
      MODE_ZEBRA: begin
        if (((frame_inc > MIN_HOLD) && head_word.loss_clear) || (frame_inc > TIMEOUT)) begin
          mode_nxt = MODE_NORMAL;
        end
      end
      default: begin
        if (go_zebra) begin
          mode_nxt = MODE_ZEBRA;
        end else if (go_cross) begin
          mode_nxt = MODE_CROSS;
        end else if (go_found) begin
          mode_nxt = MODE_FOUND;
        end else begin
          mode_nxt = MODE_NORMAL;
        end
      end
    endcase
  end

  always_comb begin
    steer         = 16'sd0;
    speed         = cfg.speed_full;
    held_nxt      = held_r;
    frame_nxt     = (mode_nxt != mode_r) ? 8'd0 : frame_inc;
    tog_nxt       = tog_r;
    prev_lost_nxt = prev_lost_r;
    gap_nxt       = gap_r;
    unique case (mode_r)
      MODE_CROSS: begin
        speed = cfg.speed_curve;
      end
      MODE_FOUND, MODE_ENTER: begin
        speed = cfg.speed_island;
        steer = held_r;
      end
      MODE_INSIDE: begin
        speed = cfg.speed_island;
        if (seen) begin
          steer    = head_word.line_offset;
          held_nxt = head_word.line_offset;
        end else begin
          steer = held_r;
        end
      end
      MODE_EXIT: begin
        speed = cfg.speed_curve;
        steer = head_word.line_offset;
      end
      MODE_ZEBRA: begin
        speed = cfg.speed_zebra;
        if (mode_nxt != mode_r) begin
          tog_nxt       = 8'd0;
          prev_lost_nxt = 1'b0;
          gap_nxt       = 16'd0;
        end
      end
      default: begin
        speed = head_word.curve ? cfg.speed_curve : cfg.speed_full;
        if (seen) begin
          steer    = head_word.line_offset;
          held_nxt = head_word.line_offset;
        end
        if (mode_nxt != MODE_NORMAL) begin
          frame_nxt     = 8'd0;
          tog_nxt       = 8'd0;
          prev_lost_nxt = 1'b1;
          gap_nxt       = 16'd0;
        end else begin
          frame_nxt     = frame_r;
          tog_nxt       = tog_upd;
          prev_lost_nxt = prev_upd;
          gap_nxt       = gap_upd;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_NORMAL;
      frame_r     <= 8'd0;
      held_r      <= 16'sd0;
      prev_lost_r <= 1'b0;
      tog_r       <= 8'd0;
      gap_r       <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        mode_r      <= mode_nxt;
        frame_r     <= frame_nxt;
        held_r      <= held_nxt;
        prev_lost_r <= prev_lost_nxt;
        tog_r       <= tog_nxt;
        gap_r       <= gap_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_word_r.mode         <= mode_nxt;
      out_word_r.steer_offset <= steer;
      out_word_r.speed_limit  <= speed;
    end
  end

endmodule

### design/line_track_mode_controller.sv
// Line-track mode controller top level: configuration registers, front end,
// word queue and back end. Depends on ltmc_pkg, ltmc_front, ltmc_queue,
// ltmc_back and the assertion macro header.
`timescale 1ns / 1ps
`include "line_track_mode_controller_macros.svh"

// One sensor word is taken per clock cycle when the result side keeps up,
// and each yields exactly one result word. The front end classifies a word
// combinationally into a two-entry queue; the back end updates the mode
// and tracking state from the queue head and writes an output register,
// so the state update loop sets the rate at one word per cycle. Either
// side may stall without blocking the other until the queue is full.
// Configuration words are always taken.

module line_track_mode_controller import ltmc_pkg::*; #(
  parameter int unsigned ZEBRA_MIN_HOLD = 20,
  parameter int unsigned ZEBRA_TIMEOUT  = 200
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_word_t               in_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_word_t              out_word,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t      cfg_r, cfg_nxt;
  cls_word_t front_word, head_word;
  logic      queue_full, queue_not_empty, head_pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !queue_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SPEED_FULL:    cfg_nxt.speed_full           = cfg_wdata[6:0];
        CFG_SPEED_CURVE:   cfg_nxt.speed_curve          = cfg_wdata[6:0];
        CFG_SPEED_ISLAND:  cfg_nxt.speed_island         = cfg_wdata[6:0];
        CFG_SPEED_ZEBRA:   cfg_nxt.speed_zebra          = cfg_wdata[6:0];
        CFG_LOSS_CONFIRM:  cfg_nxt.loss_confirm         = cfg_wdata[7:0];
        CFG_ZEBRA_TOGGLES: cfg_nxt.zebra_toggles_needed = cfg_wdata[7:0];
        CFG_ZEBRA_MAX_GAP: cfg_nxt.zebra_max_gap        = cfg_wdata;
        CFG_ISLAND_SHIELD: cfg_nxt.island_shield        = cfg_wdata[7:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ltmc_front u_front (
    .in_word      (in_word),
    .loss_confirm (cfg_r.loss_confirm),
    .cls_word     (front_word)
  );

  ltmc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_word (front_word),
    .full      (queue_full),
    .pop       (head_pop),
    .not_empty (queue_not_empty),
    .head_word (head_word)
  );

  ltmc_back #(
    .ZEBRA_MIN_HOLD (ZEBRA_MIN_HOLD),
    .ZEBRA_TIMEOUT  (ZEBRA_TIMEOUT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (queue_not_empty),
    .head_word  (head_word),
    .head_pop   (head_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

  `LTMC_ASSERT_NEXT(a_push_fills_queue, in_valid && in_ready, queue_not_empty, "accepted word missing from queue")
  `LTMC_ASSERT_NOW(a_mode_code_valid, out_valid, out_word.mode != 3'd7, "result carries an unused mode code")
  `LTMC_ASSERT_NOW(a_zebra_no_steer, out_valid && (out_word.mode == MODE_ZEBRA), out_word.steer_offset == 16'sd0, "zebra stop word steers")
  `LTMC_ASSERT_NOW(a_cross_no_steer, out_valid && (out_word.mode == MODE_CROSS), out_word.steer_offset == 16'sd0, "crossing word steers")

endmodule

### bench/testbench.sv
// Self-checking testbench for the line-track mode controller.
// Drives sensor words and settings, predicts each result word and compares it.
// Depends on ltmc_pkg and the line_track_mode_controller RTL.
`timescale 1ns / 1ps

module testbench;
  import ltmc_pkg::*;

  localparam int ZEBRA_HOLD  = 20;
  localparam int ZEBRA_LIMIT = 200;
  localparam int SIDE_IN     = 0;
  localparam int SIDE_OUT    = 1;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_word_t               in_word = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_word_t              out_word;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_SPEED_FULL;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  in_word_t  pending_frames[$];
  out_word_t awaited_results[$];

  mode_t              trk_mode = MODE_NORMAL;
  logic [7:0]         trk_frames = '0;
  logic signed [15:0] trk_held = '0;
  logic               trk_prev_lost = 1'b0;
  logic [7:0]         trk_toggles = '0;
  logic [15:0]        trk_gap = '0;
  cfg_t               trk_cfg = CFG_RESET;

  logic               in_taken = 1'b0;
  logic               no_idle = 1'b0;
  int                 in_gap = 0;
  int                 out_gap = 0;
  int                 in_burst;
  int                 out_burst;
  int                 calm_left[2] = '{0, 0};
  int                 err_count = 0;
  int                 frames_queued = 0;
  int                 frames_taken = 0;
  int                 results_checked = 0;
  int                 settings_loaded = 0;
  int                 mode_hits[8] = '{default: 0};
  logic signed [15:0] corner_offs[0:6] = '{16'sh8000, 16'sh7FFF, 16'sh8001, 16'sd500,
                                           16'sd501, -16'sd500, -16'sd501};

  line_track_mode_controller #(
    .ZEBRA_MIN_HOLD(ZEBRA_HOLD),
    .ZEBRA_TIMEOUT (ZEBRA_LIMIT)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void enter_mode(mode_t m);
    trk_mode = m;
    trk_frames = '0;
    trk_toggles = '0;
    trk_prev_lost = 1'b1;
    trk_gap = '0;
  endfunction

  function automatic out_word_t track_frame(in_word_t w);
    out_word_t          r;
    logic               left_gone;
    logic               right_gone;
    logic               all_gone;
    logic signed [15:0] steer;
    logic [6:0]         speed;
    int                 mag;
    left_gone = (w.pattern[3:0] == 4'h0);
    right_gone = (w.pattern[7:4] == 4'h0);
    all_gone = left_gone && right_gone;
    steer = '0;
    speed = trk_cfg.speed_full;
    case (trk_mode)
      MODE_CROSS: begin
        speed = trk_cfg.speed_curve;
        trk_frames = trk_frames + 8'd1;
        if (!all_gone && trk_frames > 8'd10) begin
          trk_mode = MODE_NORMAL;
          trk_frames = '0;
        end
      end
      MODE_FOUND: begin
        speed = trk_cfg.speed_island;
        steer = trk_held;
        trk_frames = trk_frames + 8'd1;
        if (trk_frames > 8'd8) begin
          trk_mode = MODE_ENTER;
          trk_frames = '0;
        end
      end
      MODE_ENTER: begin
        speed = trk_cfg.speed_island;
        steer = trk_held;
        trk_frames = trk_frames + 8'd1;
        if (trk_frames > 8'd15) begin
          trk_mode = MODE_INSIDE;
          trk_frames = '0;
        end
      end
      MODE_INSIDE: begin
        speed = trk_cfg.speed_island;
        if (!all_gone) begin
          steer = w.line_offset;
          trk_held = w.line_offset;
        end else begin
          steer = trk_held;
        end
        trk_frames = trk_frames + 8'd1;
        if (!all_gone && trk_frames > 8'd30) begin
          trk_mode = MODE_EXIT;
          trk_frames = '0;
        end
      end
      MODE_EXIT: begin
        speed = trk_cfg.speed_curve;
        steer = w.line_offset;
        trk_frames = trk_frames + 8'd1;
        if (trk_frames > trk_cfg.island_shield) begin
          trk_mode = MODE_NORMAL;
          trk_frames = '0;
        end
      end
      MODE_ZEBRA: begin
        speed = trk_cfg.speed_zebra;
        trk_frames = trk_frames + 8'd1;
        if ((trk_frames > ZEBRA_HOLD && w.left_loss_frames == 8'd0 &&
             w.right_loss_frames == 8'd0) || trk_frames > ZEBRA_LIMIT) begin
          trk_mode = MODE_NORMAL;
          trk_frames = '0;
          trk_toggles = '0;
          trk_prev_lost = 1'b0;
          trk_gap = '0;
        end
      end
      default: begin
        if (!all_gone) begin
          steer = w.line_offset;
          trk_held = w.line_offset;
        end
        mag = (w.line_offset < 0) ? -int'(w.line_offset) : int'(w.line_offset);
        speed = (mag > 500) ? trk_cfg.speed_curve : trk_cfg.speed_full;
        if (trk_gap != 16'hFFFF) trk_gap = trk_gap + 16'd1;
        if (all_gone != trk_prev_lost) begin
          if (trk_toggles != 8'd0 && trk_gap > trk_cfg.zebra_max_gap) trk_toggles = '0;
          trk_toggles = trk_toggles + 8'd1;
          trk_prev_lost = all_gone;
          trk_gap = '0;
        end
        if (all_gone && trk_toggles >= trk_cfg.zebra_toggles_needed) begin
          enter_mode(MODE_ZEBRA);
        end else if (all_gone && w.left_loss_frames >= trk_cfg.loss_confirm &&
                     w.right_loss_frames >= trk_cfg.loss_confirm && trk_toggles <= 8'd1) begin
          enter_mode(MODE_CROSS);
        end else if ((left_gone && !right_gone && w.left_loss_frames >= trk_cfg.loss_confirm) ||
                     (right_gone && !left_gone &&
                      w.right_loss_frames >= trk_cfg.loss_confirm)) begin
          enter_mode(MODE_FOUND);
        end
      end
    endcase
    r.mode = trk_mode;
    r.steer_offset = steer;
    r.speed_limit = speed;
    return r;
  endfunction

  function automatic int idle_burst(int side);
    if (no_idle) return 0;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(19) == 0) begin
      calm_left[side] = $urandom_range(80, 20);
      return 0;
    end
    return ($urandom_range(3) == 0) ? int'($urandom_range(5, 1)) : 0;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= 50) $display("MISMATCH at %0t ns, result word %0d: %s", $time,
                                  results_checked, msg);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else begin
        in_burst = idle_burst(SIDE_IN);
        if (in_burst > 0 || pending_frames.size() == 0) begin
          in_gap <= (in_burst > 0) ? in_burst - 1 : 0;
          in_valid <= 1'b0;
        end else begin
          in_word <= pending_frames.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_burst = idle_burst(SIDE_OUT);
      out_ready <= (out_burst == 0);
      out_gap <= (out_burst > 0) ? out_burst - 1 : 0;
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    in_taken = rst_n && in_valid && in_ready;
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SPEED_FULL:    trk_cfg.speed_full = cfg_wdata[6:0];
        CFG_SPEED_CURVE:   trk_cfg.speed_curve = cfg_wdata[6:0];
        CFG_SPEED_ISLAND:  trk_cfg.speed_island = cfg_wdata[6:0];
        CFG_SPEED_ZEBRA:   trk_cfg.speed_zebra = cfg_wdata[6:0];
        CFG_LOSS_CONFIRM:  trk_cfg.loss_confirm = cfg_wdata[7:0];
        CFG_ZEBRA_TOGGLES: trk_cfg.zebra_toggles_needed = cfg_wdata[7:0];
        CFG_ZEBRA_MAX_GAP: trk_cfg.zebra_max_gap = cfg_wdata;
        CFG_ISLAND_SHIELD: trk_cfg.island_shield = cfg_wdata[7:0];
        default: ;
      endcase
    end
    if (in_taken) begin
      awaited_results.push_back(track_frame(in_word));
      frames_taken++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result word arrived with nothing awaited");
      end else begin
        want = awaited_results.pop_front();
        if (out_word.mode !== want.mode)
          report_mismatch($sformatf("mode %0d, expected %0d", out_word.mode, want.mode));
        if (out_word.steer_offset !== want.steer_offset)
          report_mismatch($sformatf("steer_offset %0d, expected %0d",
                                    out_word.steer_offset, want.steer_offset));
        if (out_word.speed_limit !== want.speed_limit)
          report_mismatch($sformatf("speed_limit %0d, expected %0d",
                                    out_word.speed_limit, want.speed_limit));
        mode_hits[want.mode]++;
        results_checked++;
      end
    end
  end

  function automatic logic [7:0] pick_pattern();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return {4'($urandom_range(15, 1)), 4'h0};
      2: return {4'h0, 4'($urandom_range(15, 1))};
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] seen_pattern();
    return {4'($urandom_range(15, 1)), 4'($urandom_range(15, 1))};
  endfunction

  function automatic logic signed [15:0] pick_offset();
    case ($urandom_range(7))
      0: return corner_offs[$urandom_range(6)];
      1, 2, 3: return 16'(int'($urandom_range(1200)) - 600);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_loss();
    int lc;
    int v;
    lc = trk_cfg.loss_confirm;
    case ($urandom_range(3))
      0: v = 0;
      1: v = lc + int'($urandom_range(3));
      2: v = lc - 1;
      default: v = $urandom_range(255);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic logic [7:0] loss_at_least();
    return 8'($urandom_range(255, trk_cfg.loss_confirm));
  endfunction

  function automatic logic [7:0] loss_below();
    return (trk_cfg.loss_confirm == 8'd0) ? 8'd0 : 8'($urandom_range(trk_cfg.loss_confirm - 1));
  endfunction

  task automatic push_frame(logic [7:0] pat, logic signed [15:0] off, logic [7:0] ll,
                            logic [7:0] rl);
    in_word_t w;
    w.pattern = pat;
    w.line_offset = off;
    w.left_loss_frames = ll;
    w.right_loss_frames = rl;
    pending_frames.push_back(w);
    frames_queued++;
  endtask

  task automatic noise_run();
    repeat ($urandom_range(15, 4)) push_frame(pick_pattern(), pick_offset(), pick_loss(),
                                              pick_loss());
  endtask

  task automatic crossing_run();
    push_frame(8'h00, pick_offset(), loss_at_least(), loss_at_least());
    repeat ($urandom_range(16, 9))
      push_frame(($urandom_range(4) == 0) ? 8'h00 : seen_pattern(), pick_offset(),
                 pick_loss(), pick_loss());
  endtask

  task automatic island_run();
    int hold;
    hold = 9 + 16 + 31 + $urandom_range(6) +
           ((trk_cfg.island_shield == 8'd255) ? 30 : int'(trk_cfg.island_shield) + 1);
    if ($urandom_range(1))
      push_frame({4'($urandom_range(15, 1)), 4'h0}, pick_offset(), loss_at_least(),
                 pick_loss());
    else
      push_frame({4'h0, 4'($urandom_range(15, 1))}, pick_offset(), pick_loss(),
                 loss_at_least());
    repeat (hold)
      push_frame(($urandom_range(6) == 0) ? 8'h00 : seen_pattern(), pick_offset(),
                 pick_loss(), pick_loss());
  endtask

  task automatic zebra_run();
    int need;
    int n;
    int hold;
    need = (trk_cfg.zebra_toggles_needed > 8'd16) ? 16 : int'(trk_cfg.zebra_toggles_needed);
    repeat ($urandom_range(3, 1)) push_frame(seen_pattern(), pick_offset(), 8'd0, 8'd0);
    for (int t = 0; t < need + 2; t++) begin
      n = $urandom_range(3, 1);
      if (t % 2 == 0) begin
        repeat (n) push_frame(8'h00, pick_offset(), loss_below(), loss_below());
      end else begin
        if (trk_cfg.zebra_max_gap < 16'd100 && $urandom_range(7) == 0)
          n += int'(trk_cfg.zebra_max_gap);
        repeat (n) push_frame(seen_pattern(), pick_offset(), pick_loss(), pick_loss());
      end
    end
    hold = ($urandom_range(5) == 0) ? 205 : $urandom_range(30, 18);
    repeat (hold) push_frame(pick_pattern(), pick_offset(), 8'($urandom_range(255, 1)),
                             pick_loss());
    repeat ($urandom_range(4, 1)) push_frame(seen_pattern(), pick_offset(), 8'd0, 8'd0);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_frames.size() != 0 || in_valid || awaited_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(int n);
    int goal;
    goal = frames_queued + n;
    while (frames_queued < goal) begin
      case ($urandom_range(5))
        0, 1: noise_run();
        2: crossing_run();
        3: island_run();
        default: zebra_run();
      endcase
    end
    wait_drained();
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk);
    while (!cfg_ready);
  endtask

  task automatic load_settings(cfg_t s);
    write_reg(CFG_SPEED_FULL, 16'(s.speed_full));
    write_reg(CFG_SPEED_CURVE, 16'(s.speed_curve));
    write_reg(CFG_SPEED_ISLAND, 16'(s.speed_island));
    write_reg(CFG_SPEED_ZEBRA, 16'(s.speed_zebra));
    write_reg(CFG_LOSS_CONFIRM, 16'(s.loss_confirm));
    write_reg(CFG_ZEBRA_TOGGLES, 16'(s.zebra_toggles_needed));
    write_reg(CFG_ZEBRA_MAX_GAP, s.zebra_max_gap);
    write_reg(CFG_ISLAND_SHIELD, 16'(s.island_shield));
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  initial begin : stimulus
    cfg_t s;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_frame(8'hFF, 16'sh7FFF, 8'd0, 8'd0);
    push_frame(8'hFF, 16'sh8000, 8'd255, 8'd255);
    push_frame(8'h00, 16'sh8001, 8'd0, 8'd0);
    push_frame(8'h81, 16'sd500, 8'd0, 8'd0);
    push_frame(8'h18, 16'sd501, 8'd4, 8'd4);
    push_frame(8'h55, -16'sd500, 8'd0, 8'd255);
    push_frame(8'hAA, -16'sd501, 8'd255, 8'd0);
    push_frame(8'h0F, 16'sd1, 8'd0, 8'd4);
    push_frame(8'hF0, -16'sd1, 8'd4, 8'd255);
    push_frame(8'h00, 16'sd0, 8'd5, 8'd5);
    push_frame(8'h01, 16'sh7FFF, 8'd0, 8'd0);
    push_frame(8'h00, 16'sd0, 8'd255, 8'd255);
    push_frame(8'h80, 16'sh8000, 8'd0, 8'd0);
    push_frame(8'hF0, 16'sd77, 8'd5, 8'd0);
    repeat (10) push_frame(8'h00, 16'sd300, 8'd0, 8'd0);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: s = CFG_RESET;
        1: s = '{zebra_toggles_needed: 8'd1, default: '0};
        2: s = '{speed_full: 7'd100, speed_curve: 7'd100, speed_island: 7'd100,
                 speed_zebra: 7'd100, loss_confirm: 8'd255, zebra_toggles_needed: 8'd255,
                 zebra_max_gap: 16'hFFFF, island_shield: 8'd254};
        default: begin
          s.speed_full = 7'($urandom_range(100));
          s.speed_curve = 7'($urandom_range(100));
          s.speed_island = 7'($urandom_range(100));
          s.speed_zebra = 7'($urandom_range(100));
          s.loss_confirm = 8'($urandom_range(8));
          s.zebra_toggles_needed = 8'($urandom_range(8, 1));
          s.zebra_max_gap = $urandom_range(1) ? 16'($urandom_range(40)) : 16'($urandom);
          s.island_shield = 8'($urandom_range(50));
        end
      endcase
      // Zero toggle threshold and a shield that the frame count can never pass.
      if (p == 3) begin
        s.zebra_toggles_needed = 8'd0;
        s.island_shield = 8'd255;
      end
      load_settings(s);
      if (p == 7) no_idle = 1'b1;
      run_phase(160);
    end
    repeat (10) @(posedge clk);

    $display("Sent %0d sensor words and checked %0d result words under %0d settings.",
             frames_taken, results_checked, settings_loaded);
    $display("Results per mode: normal %0d, crossing %0d, found %0d, enter %0d, inside %0d, exit %0d, zebra %0d.",
             mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4],
             mode_hits[5], mode_hits[6]);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches found.", err_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Timed out with %0d words pending and %0d results awaited.",
             pending_frames.size(), awaited_results.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
